// ===== hw/rtl/p2ipcm_pkg.sv =====
package p2ipcm_pkg;

	// Output encodings held in the sample_format register. Code 3 is unused
	// and encodes as float passthrough.
	typedef enum logic [1:0] {
		FMT_FLOAT = 2'd0,
		FMT_INT16 = 2'd1,
		FMT_INT32 = 2'd2
	} fmt_t;

	// Register indexes on the configuration port (byte address is 4 * index).
	typedef enum logic [1:0] {
		REG_FORMAT   = 2'd0,
		REG_SRC_CHAN = 2'd1,
		REG_DST_CHAN = 2'd2
	} reg_idx_t;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_FRAMES_DEF   = 1024;

	// Full-scale multipliers for the two integer encodings.
	localparam logic [30:0] SCALE_INT16 = 31'd32767;
	localparam logic [30:0] SCALE_INT32 = 31'h7FFF_FFFF;

	localparam logic [3:0] DST_CHAN_RESET = 4'd2;

endpackage

// ===== hw/rtl/p2ipcm_ram.sv =====
module p2ipcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/planar_to_interleaved_pcm_converter.sv =====
// Planar-to-interleaved PCM converter. A word is accepted at any clock edge
// where start is high; busy is always low, so a new word may be issued every
// cycle, stores and reads freely mixed. A store (action 0) writes sample_bits
// into the planar sample memory at channel_index, frame_index and yields no
// result. A read (action 1) yields exactly one out_word, marked by done. The
// read passes three register stages: the synchronous memory read at the
// accepting edge, the clamp and scaling multiply, then rounding, truncation
// and sign. So done is registered in the last stage together with out_word,
// and the two reach the receiver in the same cycle. The receiver
// cannot stall, so out_word must be captured in the cycle where done is high.
// A read whose channel is at or beyond either channel count returns zero. In
// int16 mode the value sits in the low 16 bits with the upper half zero.
// Reading an entry never stored returns undefined data. The sample memory
// needs no clearing pass, so the block is ready right after reset. Write
// configuration only while no read is in flight.
module planar_to_interleaved_pcm_converter #(
	parameter int MAX_CHANNELS = p2ipcm_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_FRAMES   = p2ipcm_pkg::MAX_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [2:0]  channel_index,
	input  logic [9:0]  frame_index,
	input  logic [31:0] sample_bits,
	// Result channel.
	output logic        done,
	output logic [31:0] out_word,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import p2ipcm_pkg::*;

	localparam int DEPTH = MAX_CHANNELS * MAX_FRAMES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers.
	logic [1:0] fmt_q;
	logic [3:0] src_chan_q;
	logic [3:0] dst_chan_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_FLOAT;
			src_chan_q <= '0;
			dst_chan_q <= DST_CHAN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_FORMAT:   fmt_q      <= pwdata[1:0];
				REG_SRC_CHAN: src_chan_q <= pwdata[3:0];
				REG_DST_CHAN: dst_chan_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_FORMAT:   prdata = {30'd0, fmt_q};
			REG_SRC_CHAN: prdata = {28'd0, src_chan_q};
			REG_DST_CHAN: prdata = {28'd0, dst_chan_q};
			default:      prdata = '0;
		endcase
	end

	// Command decode and memory access. Every word uses the single port, so a
	// store and a read never meet in one cycle; a read that follows a store
	// to the same entry already sees the new data.
	logic          accept;
	logic          in_store;
	logic          chan_ok;
	logic [AW-1:0] mem_addr;
	logic [31:0]   mem_rdata;

	assign accept   = start && !busy;
	assign in_store = (32'(channel_index) < 32'(MAX_CHANNELS))
		&& (32'(frame_index) < 32'(MAX_FRAMES));
	assign chan_ok  = in_store && ({1'b0, channel_index} < src_chan_q)
		&& ({1'b0, channel_index} < dst_chan_q);
	assign mem_addr = AW'(32'(channel_index) * 32'(MAX_FRAMES) + 32'(frame_index));

	p2ipcm_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.en    (accept && in_store),
		.we    (!action),
		.addr  (mem_addr),
		.wdata (sample_bits),
		.rdata (mem_rdata)
	);

	// Stage 1: read issued, memory data arrives next cycle.
	logic       valid_s1;
	logic       ok_s1;
	logic [1:0] fmt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && action;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= chan_ok;
		fmt_s1 <= fmt_q;
	end

	// Stage 2: clamp to [-1,1] and multiply the 24-bit significand by the
	// full-scale constant. The product is exact; rounding follows next stage.
	// NaN and zero or subnormal inputs give zero in both integer modes, since
	// a subnormal scaled by full scale stays far below one.
	logic [7:0]  f_exp;
	logic [22:0] f_man;
	logic        is_nan;
	logic        is_big;
	logic        zero_c;
	logic [7:0]  exp_c;
	logic [23:0] sig_c;
	logic [30:0] scale_c;

	assign f_exp  = mem_rdata[30:23];
	assign f_man  = mem_rdata[22:0];
	assign is_nan = (f_exp == 8'hFF) && (f_man != '0);
	assign is_big = (f_exp > 8'd127) || ((f_exp == 8'd127) && (f_man != '0));
	assign zero_c = is_nan || (f_exp == 8'd0) || !ok_s1;
	assign exp_c  = is_big ? 8'd127 : f_exp;
	assign sig_c  = is_big ? 24'h80_0000 : {1'b1, f_man};
	assign scale_c = (fmt_s1 == FMT_INT32) ? SCALE_INT32 : SCALE_INT16;

	logic        valid_s2;
	logic        zero_s2;
	logic        sign_s2;
	logic [7:0]  exp_s2;
	logic [54:0] prod_s2;
	logic [31:0] raw_s2;
	logic [1:0]  fmt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= zero_c;
		sign_s2 <= mem_rdata[31];
		exp_s2  <= exp_c;
		prod_s2 <= 55'(sig_c) * 55'(scale_c);
		raw_s2  <= ok_s1 ? mem_rdata : 32'd0;
		fmt_s2  <= fmt_s1;
	end

	// Stage 3: round the product to 24 (int16) or 53 (int32) significant bits,
	// nearest even, then truncate toward zero. The product's top bit position
	// is known to within one, so the dropped bit count is one of two values.
	logic        is_i32;
	logic [3:0]  drop;
	logic [54:0] keep;
	logic [54:0] low_mask;
	logic        guard;
	logic        sticky;
	logic [55:0] rnd;
	logic [8:0]  shamt;
	logic [55:0] mag;
	logic [31:0] ival;
	logic [31:0] word_c;

	assign is_i32   = (fmt_s2 == FMT_INT32);
	assign drop     = is_i32 ? (prod_s2[54] ? 4'd2 : 4'd1)
		: (prod_s2[38] ? 4'd15 : 4'd14);
	assign keep     = prod_s2 >> drop;
	assign guard    = prod_s2[6'(drop - 4'd1)];
	assign low_mask = (55'd1 << (drop - 4'd1)) - 55'd1;
	assign sticky   = |(prod_s2 & low_mask);
	assign rnd      = {1'b0, keep} + 56'(guard && (sticky || keep[0]));
	assign shamt    = 9'd150 - {1'b0, exp_s2} - {5'd0, drop};
	assign mag      = (shamt >= 9'd56) ? 56'd0 : (rnd >> shamt);
	assign ival     = zero_s2 ? 32'd0 : (sign_s2 ? (32'd0 - mag[31:0]) : mag[31:0]);

	always_comb begin
		unique case (fmt_s2)
			FMT_INT16: word_c = {16'd0, ival[15:0]};
			FMT_INT32: word_c = ival;
			default:   word_c = raw_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		out_word <= word_c;
	end

`ifndef SYNTH
	// Every result traces back to an accepted read.
	a_done_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && action, 3))
		else $error("result without a matching read");

	// Stores never produce a result.
	a_store_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !action) |-> ##3 !done)
		else $error("store produced a result");

	// An int16 result always has a clear upper half.
	a_int16_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (fmt_s2 == FMT_INT16)) |=> (out_word[31:16] == 16'd0))
		else $error("int16 result with upper bits set");

	// A read outside the shared channels, or of NaN, zero or subnormal data, returns silence in both integer modes.
	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && zero_s2 && (fmt_s2 == FMT_INT16 || fmt_s2 == FMT_INT32))
		|=> (out_word == 32'd0))
		else $error("silent read returned nonzero data");
`endif

endmodule
